@@ sv/lfs_pkg.sv @@
package lfs_pkg;

	localparam int FRAMES_DEF        = 64;
	localparam int SCAN_LEDS_DEF     = 12;
	localparam int SAMPLE_DIVIDE_DEF = 6;
	localparam int QUEUE_DEPTH       = 2;

	localparam logic [15:0] SHIFT_RESET = 16'hFFFF;
	localparam logic [7:0]  FIRST_HOLD  = 8'd255;
	localparam logic [7:0]  PRESS_SAT   = 8'd254;
	localparam logic [7:0]  LONG_LIMIT  = 8'd200;
	localparam logic [7:0]  PRESS_RESET = 8'd7;
	localparam logic [7:0]  HOLD_RESET  = 8'd50;
	localparam logic [6:0]  COUNT_RESET = 7'd64;

	typedef enum logic [1:0] {
		CMD_TICK    = 2'd0,
		CMD_WRITE   = 2'd1,
		CMD_RESTART = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		OP_NOP     = 2'd0,
		OP_TICK    = 2'd1,
		OP_WRITE   = 2'd2,
		OP_RESTART = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CFG_FRAME_HOLD     = 2'd0,
		CFG_FRAME_COUNT    = 2'd1,
		CFG_DISPLAY_ENABLE = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		op_t         op;
		logic        level;
		logic [5:0]  widx;
		logic [15:0] wword;
	} item_t;

	typedef struct packed {
		logic       led_on;
		logic [3:0] led_index;
		logic [5:0] frame_now;
		logic       button_release;
		logic       long_press;
	} result_t;

	typedef struct packed {
		logic [7:0] frame_hold;
		logic [6:0] frame_count;
		logic       display_enable;
	} cfg_t;

endpackage

@@ sv/lfs_ram.sv @@
module lfs_ram import lfs_pkg::*; #(
	parameter int WIDTH = 16,
	parameter int DEPTH = FRAMES_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/lfs_fifo.sv @@
module lfs_fifo import lfs_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             push_ok;
	logic             pop_ok;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;
	assign rdata   = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push_ok) begin
			slot_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_ok) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (pop_ok) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (push_ok && !pop_ok) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop_ok && !push_ok) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

@@ sv/lfs_front.sv @@
module lfs_front import lfs_pkg::*; #(
	parameter int FRAMES = FRAMES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  command,
	input  logic        button_level,
	input  logic [5:0]  write_index,
	input  logic [15:0] write_word,
	output item_t       item,
	output logic        item_empty,
	input  logic        item_pop
);

	item_t in_item;

	always_comb begin
		in_item       = '0;
		in_item.level = button_level;
		in_item.widx  = write_index;
		in_item.wword = write_word;
		case (cmd_t'(command))
			CMD_TICK: begin
				in_item.op = OP_TICK;
			end
			CMD_WRITE: begin
				in_item.op = (8'(write_index) < 8'(FRAMES)) ? OP_WRITE : OP_NOP;
			end
			CMD_RESTART: begin
				in_item.op = OP_RESTART;
			end
			default: begin
				in_item.op = OP_NOP;
			end
		endcase
	end

	lfs_fifo #(
		.WIDTH($bits(item_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (in_item),
		.full  (full),
		.pop   (item_pop),
		.rdata (item),
		.empty (item_empty)
	);

endmodule

@@ sv/lfs_back.sv @@
module lfs_back import lfs_pkg::*; #(
	parameter int FRAMES        = FRAMES_DEF,
	parameter int SCAN_LEDS     = SCAN_LEDS_DEF,
	parameter int SAMPLE_DIVIDE = SAMPLE_DIVIDE_DEF,
	localparam int AW  = (FRAMES > 1) ? $clog2(FRAMES) : 1,
	localparam int SDW = (SAMPLE_DIVIDE > 1) ? $clog2(SAMPLE_DIVIDE) : 1
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  item_t   item,
	input  logic    item_empty,
	output logic    item_pop,
	output result_t res,
	output logic    res_push,
	input  logic    res_full
);

	localparam logic [3:0]     LED_LAST  = 4'(SCAN_LEDS - 1);
	localparam logic [SDW-1:0] SDIV_LAST = SDW'(SAMPLE_DIVIDE - 1);

	logic [15:0]    shift_q;
	logic           pend_q;
	logic           oor_q;
	logic [3:0]     scan_q;
	logic [7:0]     sd_q;
	logic [7:0]     hold_q;
	logic [5:0]     fp_q;
	logic [SDW-1:0] sdiv_q;
	logic           last_q;
	logic [7:0]     pc_q;

	logic [15:0]    shift_eff;
	logic [15:0]    shift_nx;
	logic [3:0]     scan_nx;
	logic [7:0]     sd_nx;
	logic [7:0]     hold_nx;
	logic [5:0]     fp_nx;
	logic [6:0]     next_fp;
	logic [SDW-1:0] sdiv_nx;
	logic           last_nx;
	logic [7:0]     pc_nx;
	logic           reload;
	logic           ram_we;
	logic           go;
	logic [15:0]    ram_rdata;

	assign go       = !item_empty && !res_full;
	assign item_pop = go;
	assign res_push = go;

	assign shift_eff = pend_q ? (oor_q ? '0 : ram_rdata) : shift_q;

	always_comb begin
		scan_nx  = scan_q;
		sd_nx    = sd_q;
		hold_nx  = hold_q;
		fp_nx    = fp_q;
		next_fp  = '0;
		shift_nx = shift_eff;
		sdiv_nx  = sdiv_q;
		last_nx  = last_q;
		pc_nx    = pc_q;
		reload   = 1'b0;
		ram_we   = 1'b0;
		res      = '0;
		case (item.op)
			OP_TICK: begin
				if (cfg.display_enable) begin
					if (shift_eff[0]) begin
						res.led_on    = 1'b1;
						res.led_index = scan_q;
					end
					scan_nx  = scan_q + 4'd1;
					shift_nx = shift_eff >> 1;
					if (scan_nx > LED_LAST) begin
						scan_nx = '0;
						sd_nx   = sd_q + 8'd1;
						if (sd_nx >= hold_q) begin
							hold_nx = cfg.frame_hold;
							sd_nx   = '0;
							next_fp = {1'b0, fp_q} + 7'd1;
							if (next_fp >= cfg.frame_count) begin
								next_fp = 7'd1;
							end
							fp_nx = next_fp[5:0];
						end
						reload = 1'b1;
					end
				end
				if (sdiv_q == SDIV_LAST) begin
					sdiv_nx = '0;
					if (!item.level) begin
						pc_nx = (pc_q >= PRESS_SAT) ? PRESS_SAT : pc_q + 8'd1;
					end
					if (!last_q && item.level) begin
						res.long_press     = (pc_nx > LONG_LIMIT);
						res.button_release = 1'b1;
						pc_nx              = '0;
					end
					last_nx = item.level;
				end else begin
					sdiv_nx = sdiv_q + SDW'(1);
				end
			end
			OP_WRITE: begin
				ram_we = 1'b1;
			end
			OP_RESTART: begin
				fp_nx   = '0;
				scan_nx = '0;
				sd_nx   = '0;
				hold_nx = FIRST_HOLD;
				reload  = 1'b1;
			end
			default: begin
			end
		endcase
		res.frame_now = fp_nx;
	end

	lfs_ram #(
		.WIDTH(16),
		.DEPTH(FRAMES)
	) u_store (
		.clk  (clk),
		.we   (go && ram_we),
		.waddr(AW'(item.widx)),
		.wdata(item.wword),
		.raddr(AW'(fp_nx)),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		oor_q <= (8'(fp_nx) >= 8'(FRAMES));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= SHIFT_RESET;
			pend_q  <= 1'b0;
			scan_q  <= '0;
			sd_q    <= '0;
			hold_q  <= FIRST_HOLD;
			fp_q    <= '0;
			sdiv_q  <= '0;
			last_q  <= 1'b1;
			pc_q    <= PRESS_RESET;
		end else begin
			shift_q <= go ? shift_nx : shift_eff;
			pend_q  <= go && reload;
			if (go) begin
				scan_q <= scan_nx;
				sd_q   <= sd_nx;
				hold_q <= hold_nx;
				fp_q   <= fp_nx;
				sdiv_q <= sdiv_nx;
				last_q <= last_nx;
				pc_q   <= pc_nx;
			end
		end
	end

endmodule

@@ sv/led_frame_scanner_with_button.sv @@
// channel  | handshake   | payload
// ---------+-------------+-----------------------------------------------------
// input    | push / full | command, button_level, write_index, write_word
// result   | empty / pop | led_on, led_index, frame_now, button_release,
//          |             | long_press
// config   | cfg_write   | cfg_index, cfg_data (8 bits, no read-back)
//
// One request per clock, sustained while neither side stalls; one result per request.
// A request passes the request queue, then the executing stage, to the result side:
// that stage works on the head of the request queue and fills the result queue in
// the same clock; a frame store read is used by the request that follows.
// Either side may stall; two-entry queues on each side keep the other running.
// arst_n clears the control state but for the out-of-range flag; the frame store is not cleared.
module led_frame_scanner_with_button import lfs_pkg::*; #(
	parameter int FRAMES        = FRAMES_DEF,
	parameter int SCAN_LEDS     = SCAN_LEDS_DEF,
	parameter int SAMPLE_DIVIDE = SAMPLE_DIVIDE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  command,
	input  logic        button_level,
	input  logic [5:0]  write_index,
	input  logic [15:0] write_word,
	output logic        empty,
	input  logic        pop,
	output logic        led_on,
	output logic [3:0]  led_index,
	output logic [5:0]  frame_now,
	output logic        button_release,
	output logic        long_press,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	cfg_t    cfg_q;
	item_t   item;
	logic    item_empty;
	logic    item_pop;
	result_t res;
	logic    res_push;
	logic    res_full;
	result_t out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_hold     <= HOLD_RESET;
			cfg_q.frame_count    <= COUNT_RESET;
			cfg_q.display_enable <= 1'b1;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				CFG_FRAME_HOLD: begin
					cfg_q.frame_hold <= cfg_data;
				end
				CFG_FRAME_COUNT: begin
					cfg_q.frame_count <= cfg_data[6:0];
				end
				CFG_DISPLAY_ENABLE: begin
					cfg_q.display_enable <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	lfs_front #(
		.FRAMES(FRAMES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.command     (command),
		.button_level(button_level),
		.write_index (write_index),
		.write_word  (write_word),
		.item        (item),
		.item_empty  (item_empty),
		.item_pop    (item_pop)
	);

	lfs_back #(
		.FRAMES       (FRAMES),
		.SCAN_LEDS    (SCAN_LEDS),
		.SAMPLE_DIVIDE(SAMPLE_DIVIDE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.item      (item),
		.item_empty(item_empty),
		.item_pop  (item_pop),
		.res       (res),
		.res_push  (res_push),
		.res_full  (res_full)
	);

	lfs_fifo #(
		.WIDTH($bits(result_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_out_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res),
		.full  (res_full),
		.pop   (pop),
		.rdata (out_res),
		.empty (empty)
	);

	assign led_on         = out_res.led_on;
	assign led_index      = out_res.led_index;
	assign frame_now      = out_res.frame_now;
	assign button_release = out_res.button_release;
	assign long_press     = out_res.long_press;

endmodule

@@ sv/lfs_checker.sv @@
module lfs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       push,
	input logic       full,
	input logic       empty,
	input logic       pop,
	input logic       led_on,
	input logic [3:0] led_index,
	input logic [5:0] frame_now,
	input logic       button_release,
	input logic       long_press
);

	logic taken;

	assign taken = push && !full;

	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		empty && !taken && !$past(taken) |=> empty)
		else $error("result appeared with no request in flight");

	a_long_has_release: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && long_press |-> button_release)
		else $error("long press without release");

	a_dark_index: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !led_on |-> led_index == 4'd0)
		else $error("led index set while dark");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(frame_now))
		else $error("waiting result changed");

endmodule

bind led_frame_scanner_with_button lfs_checker u_lfs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.push          (push),
	.full          (full),
	.empty         (empty),
	.pop           (pop),
	.led_on        (led_on),
	.led_index     (led_index),
	.frame_now     (frame_now),
	.button_release(button_release),
	.long_press    (long_press)
);

@@ test/led_scan_checker.sv @@
`timescale 1ns / 100ps

module led_scan_checker import lfs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [1:0]  command,
	input  logic        button_level,
	input  logic [5:0]  write_index,
	input  logic [15:0] write_word,
	input  logic        empty,
	input  logic        pop,
	input  logic        led_on,
	input  logic [3:0]  led_index,
	input  logic [5:0]  frame_now,
	input  logic        button_release,
	input  logic        long_press,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output int          mismatches,
	output int          pending,
	output int          checked,
	output int          releases,
	output int          long_presses,
	output int          frame_moves
);

	logic [15:0] frame_words [FRAMES_DEF];
	logic [15:0] shift_word = SHIFT_RESET;
	logic [3:0]  scan_pos = '0;
	logic [7:0]  scan_div = '0;
	logic [7:0]  cur_hold = FIRST_HOLD;
	logic [5:0]  frame_pos = '0;
	logic [2:0]  sample_div = '0;
	logic        last_lvl = 1'b1;
	logic [7:0]  press_cnt = PRESS_RESET;
	logic [5:0]  last_frame = '0;
	cfg_t        regs = '{HOLD_RESET, COUNT_RESET, 1'b1};
	result_t     awaited_results [$];
	result_t     want;
	result_t     got;

	task automatic report_mismatch(input string what, input int seen, input int wanted);
		if (mismatches < 40)
			$display("%0t: %s: got %0d, expected %0d", $time, what, seen, wanted);
		mismatches++;
	endtask

	task automatic check_field(input string what, input int seen, input int wanted);
		if (seen != wanted)
			report_mismatch(what, seen, wanted);
	endtask

	task automatic predict_scan(input logic [1:0] cmd, input logic lvl, input logic [5:0] idx,
			input logic [15:0] word, output result_t res);
		int nxt;
		res = '0;
		case (cmd)
			CMD_TICK: begin
				if (regs.display_enable) begin
					if (shift_word[0]) begin
						res.led_on = 1'b1;
						res.led_index = scan_pos;
					end
					scan_pos = scan_pos + 4'd1;
					shift_word = shift_word >> 1;
					if (scan_pos > SCAN_LEDS_DEF - 1) begin
						scan_div = scan_div + 8'd1;
						scan_pos = '0;
						if (scan_div >= cur_hold) begin
							nxt = frame_pos + 1;
							cur_hold = regs.frame_hold;
							scan_div = '0;
							if (nxt >= regs.frame_count)
								nxt = 1;
							frame_pos = nxt[5:0];
						end
						shift_word = frame_words[frame_pos];
					end
				end
				sample_div = sample_div + 3'd1;
				if (sample_div > SAMPLE_DIVIDE_DEF - 1) begin
					sample_div = '0;
					if (!lvl && press_cnt < PRESS_SAT)
						press_cnt = press_cnt + 8'd1;
					if (!last_lvl && lvl) begin
						res.long_press = (press_cnt > LONG_LIMIT);
						res.button_release = 1'b1;
						press_cnt = '0;
					end
					last_lvl = lvl;
				end
			end
			CMD_WRITE: frame_words[idx] = word;
			CMD_RESTART: begin
				frame_pos = '0;
				scan_pos = '0;
				scan_div = '0;
				shift_word = frame_words[0];
				cur_hold = FIRST_HOLD;
			end
			default: ;
		endcase
		res.frame_now = frame_pos;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FRAMES_DEF; i++)
				frame_words[i] = '0;
			shift_word = SHIFT_RESET;
			scan_pos = '0;
			scan_div = '0;
			cur_hold = FIRST_HOLD;
			frame_pos = '0;
			sample_div = '0;
			last_lvl = 1'b1;
			press_cnt = PRESS_RESET;
			regs = '{HOLD_RESET, COUNT_RESET, 1'b1};
			awaited_results.delete();
			pending = 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_FRAME_HOLD:     regs.frame_hold = cfg_data;
					CFG_FRAME_COUNT:    regs.frame_count = cfg_data[6:0];
					CFG_DISPLAY_ENABLE: regs.display_enable = cfg_data[0];
					default: ;
				endcase
			end
			// take the result before the request so a same-edge result cannot match it
			if (pop && !empty) begin
				got = '{led_on, led_index, frame_now, button_release, long_press};
				if (awaited_results.size() == 0) begin
					report_mismatch("result with no request outstanding, frame",
						int'(frame_now), -1);
				end else begin
					want = awaited_results.pop_front();
					check_field("led_on", int'(got.led_on), int'(want.led_on));
					check_field("led_index", int'(got.led_index), int'(want.led_index));
					check_field("frame_now", int'(got.frame_now), int'(want.frame_now));
					check_field("button_release", int'(got.button_release),
						int'(want.button_release));
					check_field("long_press", int'(got.long_press), int'(want.long_press));
				end
				checked++;
				if (got.button_release)
					releases++;
				if (got.long_press)
					long_presses++;
				if (got.frame_now != last_frame)
					frame_moves++;
				last_frame = got.frame_now;
			end
			if (push && !full) begin
				predict_scan(command, button_level, write_index, write_word, want);
				awaited_results.push_back(want);
			end
			pending = awaited_results.size();
		end
	end

endmodule

@@ test/led_frame_scanner_with_button_tb.sv @@
`timescale 1ns / 100ps

module led_frame_scanner_with_button_tb;
	import lfs_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic        clk = 1'b1;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [1:0]  command = CMD_TICK;
	logic        button_level = 1'b1;
	logic [5:0]  write_index = '0;
	logic [15:0] write_word = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic        led_on;
	logic [3:0]  led_index;
	logic [5:0]  frame_now;
	logic        button_release;
	logic        long_press;
	logic        cfg_write = 1'b0;
	logic [1:0]  cfg_index = CFG_FRAME_HOLD;
	logic [7:0]  cfg_data = '0;

	int mismatches, pending, checked, releases, long_presses, frame_moves;
	int n_ticks = 0, n_writes = 0, n_restarts = 0, n_unused = 0, n_settings = 0;
	int hold_offs_asked = 0, hold_offs_done = 0;
	bit send_burst = 1'b0;
	bit drain_burst = 1'b0;
	logic level_now = 1'b1;
	int level_left = 0;

	led_frame_scanner_with_button u_dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full),
		.command(command), .button_level(button_level),
		.write_index(write_index), .write_word(write_word),
		.empty(empty), .pop(pop),
		.led_on(led_on), .led_index(led_index), .frame_now(frame_now),
		.button_release(button_release), .long_press(long_press),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	led_scan_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full),
		.command(command), .button_level(button_level),
		.write_index(write_index), .write_word(write_word),
		.empty(empty), .pop(pop),
		.led_on(led_on), .led_index(led_index), .frame_now(frame_now),
		.button_release(button_release), .long_press(long_press),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .pending(pending), .checked(checked),
		.releases(releases), .long_presses(long_presses), .frame_moves(frame_moves)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// button pin as runs of one level, now and then long enough for a long press
	function automatic logic next_level();
		int r;
		if (level_left == 0) begin
			level_now = !level_now;
			r = $urandom_range(0, 99);
			if (r < 70)
				level_left = $urandom_range(1, 12);
			else if (r < 97)
				level_left = $urandom_range(13, 120);
			else
				level_left = $urandom_range(1250, 1400);
		end
		level_left--;
		return level_now;
	endfunction

	task automatic send_request(input logic [1:0] cmd, input logic lvl, input logic [5:0] idx,
			input logic [15:0] word);
		int gap;
		gap = send_burst ? 0 : pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		command <= cmd;
		button_level <= lvl;
		write_index <= idx;
		write_word <= word;
		@(posedge clk);
		while (full)
			@(posedge clk);
		case (cmd)
			CMD_TICK:    n_ticks++;
			CMD_WRITE:   n_writes++;
			CMD_RESTART: n_restarts++;
			default:     n_unused++;
		endcase
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		@(posedge clk);
	endtask

	task automatic apply_settings(input logic [7:0] hold, input logic [6:0] count, input logic en);
		wait_drained();
		cfg_write <= 1'b1;
		cfg_index <= CFG_FRAME_HOLD;
		cfg_data <= hold;
		@(posedge clk);
		cfg_index <= CFG_FRAME_COUNT;
		cfg_data <= {1'b0, count};
		@(posedge clk);
		cfg_index <= CFG_DISPLAY_ENABLE;
		cfg_data <= {7'd0, en};
		@(posedge clk);
		cfg_write <= 1'b0;
		n_settings++;
	endtask

	task automatic run_phase(input int n, input int restart_pm, input int unused_pm);
		int r;
		logic [1:0] cmd;
		logic lvl;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 999);
			if (r < restart_pm)
				cmd = CMD_RESTART;
			else if (r < restart_pm + unused_pm)
				cmd = CMD_UNUSED;
			else if (r < restart_pm + unused_pm + 80)
				cmd = CMD_WRITE;
			else
				cmd = CMD_TICK;
			if (cmd == CMD_TICK)
				lvl = next_level();
			else
				lvl = 1'($urandom_range(0, 1));
			send_request(cmd, lvl, 6'($urandom_range(0, 63)), 16'($urandom_range(0, 65535)));
		end
	endtask

	initial begin
		int stall;
		stall = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (stall > 0) begin
				stall--;
				pop <= 1'b0;
			end else if (hold_offs_done != hold_offs_asked) begin
				hold_offs_done++;
				stall = $urandom_range(60, 120) - 1;
				pop <= 1'b0;
			end else if (drain_burst) begin
				pop <= 1'b1;
			end else begin
				stall = pick_gap();
				if (stall == 0) begin
					pop <= 1'b1;
				end else begin
					stall--;
					pop <= 1'b0;
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the whole frame store before anything can read it
		for (int i = 0; i < FRAMES_DEF; i++)
			send_request(CMD_WRITE, 1'b1, i[5:0],
				(i == 0) ? 16'hFFFF : (i == 63) ? 16'h0000 : 16'($urandom_range(0, 65535)));

		repeat (6) send_request(CMD_TICK, 1'b0, 6'd0, 16'h0000);
		repeat (6) send_request(CMD_TICK, 1'b1, 6'd63, 16'hFFFF);
		send_request(CMD_WRITE, 1'b0, 6'd63, 16'h0000);
		send_request(CMD_WRITE, 1'b1, 6'd0, 16'h8001);
		send_request(CMD_UNUSED, 1'b0, 6'd0, 16'h0000);
		send_request(CMD_RESTART, 1'b1, 6'd63, 16'hFFFF);
		repeat (2) send_request(CMD_TICK, 1'b1, 6'd0, 16'h0000);
		apply_settings(8'd0, 7'd0, 1'b0);
		repeat (4) send_request(CMD_TICK, 1'b0, 6'd0, 16'h0000);

		// hold the button long enough for the press count to saturate, then let go
		apply_settings(8'd1, 7'd5, 1'b1);
		level_now = 1'b0;
		level_left = 1560;
		for (int k = 0; k < 1565; k++)
			send_request(CMD_TICK, next_level(), 6'd0, 16'h0000);

		apply_settings(8'd0, 7'd127, 1'b1);
		send_burst = 1'b1;
		drain_burst = 1'b1;
		run_phase(25, 0, 10);
		send_burst = 1'b0;
		drain_burst = 1'b0;
		run_phase(15, 0, 10);

		apply_settings(8'd1, 7'd0, 1'b1);
		run_phase(10, 0, 10);

		apply_settings(8'd255, 7'd64, 1'b1);
		run_phase(10, 0, 10);

		apply_settings(8'd18, 7'd64, 1'b0);
		run_phase(10, 0, 10);

		apply_settings(8'd18, 7'd7, 1'b1);
		send_burst = 1'b1;
		hold_offs_asked++;
		run_phase(15, 0, 10);
		send_burst = 1'b0;
		run_phase(5, 0, 10);
		wait_drained();
		run_phase(5, 0, 10);

		apply_settings(8'd1, 7'd1, 1'b1);
		run_phase(10, 0, 10);

		apply_settings(8'd50, 7'd64, 1'b1);
		hold_offs_asked++;
		run_phase(20, 50, 10);

		wait_drained();
		repeat (8) @(posedge clk);
		$display("stimulus: %0d requests (%0d ticks, %0d frame writes, %0d restarts, %0d unused)",
			n_ticks + n_writes + n_restarts + n_unused, n_ticks, n_writes, n_restarts, n_unused);
		$display("results: %0d checked over %0d settings, %0d releases, %0d long presses,",
			checked, n_settings, releases, long_presses);
		$display("         %0d frame changes", frame_moves);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/lfs_pkg.sv
sv/lfs_ram.sv
sv/lfs_fifo.sv
sv/lfs_front.sv
sv/lfs_back.sv
sv/led_frame_scanner_with_button.sv
sv/lfs_checker.sv
test/led_scan_checker.sv
test/led_frame_scanner_with_button_tb.sv
